>>> rtl/slt_pkg.sv
// Shared types, codes and sizes for the sorted list table.
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_POP    = 3'd3;
  localparam logic [2:0] OP_DUMP   = 3'd4;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOTFOUND = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;
  localparam logic [1:0] STS_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_POP,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic               found;
    logic signed [31:0] key;
  } cell_ctrl_t;

endpackage

>>> rtl/slt_cell.sv
// One slot of the list: holds one entry and shifts toward its neighbors on command.
module slt_cell (
  input  logic                clk,
  input  slt_pkg::cell_ctrl_t ctrl,
  input  logic                valid_i,
  input  logic                is_tail_i,
  input  logic                prev_lt_i,
  input  logic signed [31:0]  left_data_i,
  input  logic signed [31:0]  right_data_i,
  input  logic signed [31:0]  head_data_i,
  output logic signed [31:0]  data_o,
  output logic                lt_o,
  output logic                eq_o
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  assign lt_o   = valid_i && (data_r < ctrl.key);
  assign eq_o   = valid_i && (data_r == ctrl.key);
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      slt_pkg::CMD_INSERT: begin
        // Entries below the key stay; the first slot not below it takes the key.
        if (!lt_o) begin
          data_nxt = prev_lt_i ? ctrl.key : left_data_i;
        end
      end
      slt_pkg::CMD_DELETE: begin
        // Equal entries are contiguous, so every slot from the first match on closes up.
        if (ctrl.found && !lt_o) begin
          data_nxt = right_data_i;
        end
      end
      slt_pkg::CMD_POP:    data_nxt = right_data_i;
      slt_pkg::CMD_ROTATE: data_nxt = is_tail_i ? head_data_i : right_data_i;
      default:             data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> rtl/sorted_list_table_top.sv
// Top level of the sorted list table: control, output register and the row of cells.
//
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_tvalid/tready   | in_tdata: op, value
//  out     | output    | out_tvalid/tready  | out_tdata: status, result_value, entry_count;
//          |           |                    | out_tlast: last
//
// An item is accepted in the idle state and executed in the exec state once the
// output register is free; a dump of a non-empty table then emits one result per
// stored entry, and the cells rotate one slot per emitted item.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.
// A stalled output holds its item and the block waits before touching the cells.
module sorted_list_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] op, [34:3] value, [39:35] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [33:2] result_value,
                                  // [38:34] entry_count, [39] zero
  output logic        out_tlast
);

  localparam int CAP = slt_pkg::CAPACITY;
  localparam int CW  = slt_pkg::CNT_W;

  slt_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      dump_left_r, dump_left_nxt;
  logic [2:0]         op_r;
  logic signed [31:0] key_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic [4:0]         out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               accept;
  logic               full;
  logic               empty;
  logic               found;
  slt_pkg::cell_cmd_t  cell_cmd;
  slt_pkg::cell_ctrl_t ctrl;

  logic signed [31:0] cell_data [CAP];
  logic [CAP-1:0]     cell_lt;
  logic [CAP-1:0]     cell_eq;

  assign in_tready  = (state_r == slt_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign full       = (count_r == CW'(CAP));
  assign empty      = (count_r == '0);
  assign found      = |cell_eq;
  assign ctrl       = '{cmd: cell_cmd, found: found, key: key_r};

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_count_r, out_value_r, out_status_r};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic               prev_lt;
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;

    if (i == 0) begin : g_first
      assign prev_lt   = 1'b1;
      assign left_data = key_r;
    end else begin : g_inner
      assign prev_lt   = cell_lt[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAP - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    slt_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .valid_i      (CW'(i) < count_r),
      .is_tail_i    (CW'(i + 1) == count_r),
      .prev_lt_i    (prev_lt),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .head_data_i  (cell_data[0]),
      .data_o       (cell_data[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = slt_pkg::ST_EXEC;
        end
      end
      slt_pkg::ST_EXEC: begin
        if (op_r > slt_pkg::OP_DUMP) begin
          state_nxt = slt_pkg::ST_IDLE;
        end else if (out_free) begin
          state_nxt = (op_r == slt_pkg::OP_DUMP && !empty) ? slt_pkg::ST_DUMP
                                                           : slt_pkg::ST_IDLE;
        end
      end
      slt_pkg::ST_DUMP: begin
        if (out_free && dump_left_r == CW'(1)) begin
          state_nxt = slt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slt_pkg::ST_IDLE;
    endcase
  end

  // Cell commands, count and result loading.
  always_comb begin
    cell_cmd       = slt_pkg::CMD_HOLD;
    count_nxt      = count_r;
    dump_left_nxt  = dump_left_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      slt_pkg::ST_IDLE: ;
      slt_pkg::ST_EXEC: begin
        if (out_free && op_r <= slt_pkg::OP_DUMP) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = slt_pkg::STS_OK;
          out_value_nxt  = key_r;
          out_last_nxt   = 1'b1;
          unique case (op_r)
            slt_pkg::OP_INSERT: begin
              if (full) begin
                out_status_nxt = slt_pkg::STS_FULL;
              end else begin
                cell_cmd  = slt_pkg::CMD_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            slt_pkg::OP_SEARCH: begin
              if (!found) begin
                out_status_nxt = slt_pkg::STS_NOTFOUND;
              end
            end
            slt_pkg::OP_DELETE: begin
              if (found) begin
                cell_cmd  = slt_pkg::CMD_DELETE;
                count_nxt = count_r - CW'(1);
              end else begin
                out_status_nxt = slt_pkg::STS_NOTFOUND;
              end
            end
            slt_pkg::OP_POP: begin
              if (empty) begin
                out_status_nxt = slt_pkg::STS_EMPTY;
                out_value_nxt  = '0;
              end else begin
                out_value_nxt = cell_data[0];
                cell_cmd      = slt_pkg::CMD_POP;
                count_nxt     = count_r - CW'(1);
              end
            end
            slt_pkg::OP_DUMP: begin
              if (empty) begin
                out_status_nxt = slt_pkg::STS_EMPTY;
                out_value_nxt  = '0;
              end else begin
                // Results come from the dump state, one per entry.
                out_valid_nxt = 1'b0;
                dump_left_nxt = count_r;
              end
            end
            default: out_valid_nxt = 1'b0;
          endcase
          out_count_nxt = 5'(count_nxt);
        end
      end
      slt_pkg::ST_DUMP: begin
        if (out_free) begin
          // The head is emitted and the list rotates so the next entry reaches slot 0.
          cell_cmd       = slt_pkg::CMD_ROTATE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = slt_pkg::STS_OK;
          out_value_nxt  = cell_data[0];
          out_count_nxt  = 5'(count_r);
          out_last_nxt   = (dump_left_r == CW'(1));
          dump_left_nxt  = dump_left_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slt_pkg::ST_IDLE;
      count_r     <= '0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_left_r <= dump_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tdata[2:0];
      key_r <= in_tdata[34:3];
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("entry count above capacity");

  a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == slt_pkg::ST_DUMP |=> count_r == $past(count_r))
    else $error("entry count changed during a dump");

  a_dump_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == slt_pkg::ST_DUMP |-> dump_left_r != '0)
    else $error("dump state with nothing left to emit");

  for (genvar i = 1; i < CAP; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r != slt_pkg::ST_DUMP && CW'(i) < count_r) |->
        cell_data[i-1] <= cell_data[i])
      else $error("stored entries out of order");
  end

endmodule

>>> tb/sv/tb_sorted_list_table_top.sv
// Testbench for the sorted list table: random streams of list operations checked against a predictor.
`timescale 1ns / 1ps

module tb_sorted_list_table_top;

  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
  localparam int RANDOM_ITEMS  = 430;
  localparam int QUIET_ITEMS   = 60;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 40;
  localparam int WATCHDOG_MAX  = 2000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [4:0]         count;
    logic               last;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] keys[$];
    list_result_t       expected_q[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int find_key(logic signed [31:0] key);
      foreach (keys[i])
        if (keys[i] == key) return i;
      return -1;
    endfunction

    // A key that is stored right now when the table holds any, so searches and deletes can hit.
    function logic signed [31:0] stored_key();
      if (keys.size() == 0) return $urandom;
      return keys[$urandom_range(0, keys.size() - 1)];
    endfunction

    function void expect_result(logic [1:0] status, logic signed [31:0] value, logic last);
      list_result_t r;
      r.status = status;
      r.value  = value;
      r.count  = 5'(keys.size());
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    function void note_input(logic [2:0] op, logic signed [31:0] key);
      int pos;
      int hit;
      case (op)
        slt_pkg::OP_INSERT: begin
          if (keys.size() >= slt_pkg::CAPACITY) begin
            expect_result(slt_pkg::STS_FULL, key, 1'b1);
          end else begin
            pos = 0;
            while (pos < keys.size() && keys[pos] < key) pos++;
            keys.insert(pos, key);
            expect_result(slt_pkg::STS_OK, key, 1'b1);
          end
        end
        slt_pkg::OP_SEARCH: begin
          hit = find_key(key);
          expect_result(hit >= 0 ? slt_pkg::STS_OK : slt_pkg::STS_NOTFOUND, key, 1'b1);
        end
        slt_pkg::OP_DELETE: begin
          hit = find_key(key);
          if (hit >= 0) keys.delete(hit);
          expect_result(hit >= 0 ? slt_pkg::STS_OK : slt_pkg::STS_NOTFOUND, key, 1'b1);
        end
        slt_pkg::OP_POP: begin
          if (keys.size() == 0) begin
            expect_result(slt_pkg::STS_EMPTY, '0, 1'b1);
          end else begin
            key = keys.pop_front();
            expect_result(slt_pkg::STS_OK, key, 1'b1);
          end
        end
        slt_pkg::OP_DUMP: begin
          if (keys.size() == 0) expect_result(slt_pkg::STS_EMPTY, '0, 1'b1);
          else foreach (keys[i])
            expect_result(slt_pkg::STS_OK, keys[i], i == keys.size() - 1);
        end
        default: ;  // reserved codes leave the table alone and give nothing back
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d value %0h count %0d",
                 $time, got.status, got.value, got.count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("result_value", want.value, got.value);
      compare_field("entry_count", want.count, got.count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  logic        quiet;
  logic        long_hold;
  int          stall_cycles;

  list_scoreboard sb = new();

  sorted_list_table_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata[1:0], out_tdata[33:2], out_tdata[38:34], out_tlast});
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: short random stalls, and one long hold-off when asked for.
  initial begin : receiver
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        held = 1'b1;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic signed [31:0] value);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {5'b0, value, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, value);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = {5'b0, 32'($urandom), 3'($urandom)};
    end
  endtask

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 15)) - 8;
    if (r < 6) return sb.stored_key();
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Fill, drain and mixed phases walk the table between empty and full.
  function automatic logic [2:0] pick_op(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 60) return slt_pkg::OP_INSERT;
        if (r < 70) return slt_pkg::OP_SEARCH;
        if (r < 80) return slt_pkg::OP_DELETE;
        if (r < 88) return slt_pkg::OP_POP;
        if (r < 97) return slt_pkg::OP_DUMP;
      end
      1: begin
        if (r < 15) return slt_pkg::OP_INSERT;
        if (r < 25) return slt_pkg::OP_SEARCH;
        if (r < 55) return slt_pkg::OP_DELETE;
        if (r < 85) return slt_pkg::OP_POP;
        if (r < 97) return slt_pkg::OP_DUMP;
      end
      default: begin
        if (r < 35) return slt_pkg::OP_INSERT;
        if (r < 55) return slt_pkg::OP_SEARCH;
        if (r < 72) return slt_pkg::OP_DELETE;
        if (r < 83) return slt_pkg::OP_POP;
        if (r < 97) return slt_pkg::OP_DUMP;
      end
    endcase
    return 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
  endfunction

  initial begin : stimulus
    int sent;
    int phase;
    logic [2:0] op;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    quiet        = 1'b0;
    long_hold    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Dump, pop, search and delete on an empty table.
    send_item(slt_pkg::OP_DUMP, 32'sh1234_5678);
    send_item(slt_pkg::OP_POP, -32'sd5);
    send_item(slt_pkg::OP_SEARCH, 32'sd0);
    send_item(slt_pkg::OP_DELETE, 32'sd0);
    // Extreme keys and a duplicate.
    send_item(slt_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_item(slt_pkg::OP_INSERT, 32'sh8000_0000);
    send_item(slt_pkg::OP_INSERT, 32'sd0);
    send_item(slt_pkg::OP_INSERT, -32'sd1);
    send_item(slt_pkg::OP_INSERT, 32'sd0);
    send_item(slt_pkg::OP_DUMP, 32'sd0);
    send_item(slt_pkg::OP_SEARCH, 32'sh8000_0000);
    send_item(slt_pkg::OP_SEARCH, 32'sd7);
    send_item(slt_pkg::OP_DELETE, 32'sd0);
    send_item(slt_pkg::OP_DELETE, 32'sd9);
    send_item(OP_RESERVED_FIRST, 32'sd3);
    send_item(OP_RESERVED_FIRST + 3'd1, -32'sd3);
    send_item(OP_RESERVED_LAST, 32'sh7fff_ffff);
    send_item(slt_pkg::OP_POP, 32'sd0);
    send_item(slt_pkg::OP_DUMP, 32'sd0);
    send_item(slt_pkg::OP_SEARCH, 32'sd0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 30 == 0) phase = $urandom_range(0, 2);
      if (sent == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (sent == RANDOM_ITEMS / 2) begin
        // Hold the receiver off and push a dump into it so the block backs up.
        long_hold = 1'b1;
        send_item(slt_pkg::OP_DUMP, pick_key());
        sent++;
      end
      if (!quiet && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 5));
      op = pick_op(phase);
      send_item(op, pick_key());
      if (op <= slt_pkg::OP_DUMP) sent++;
    end
    idle_input(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
